>>> sv/asrs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the averaged range sensor scaler.
// No dependencies; imported by every module of the block.
package asrs_pkg;

	localparam int WINDOW_LEN_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 12;

	localparam int ADC_W      = 12;     // width of floor and full-scale registers
	localparam int DIST_W     = 16;     // distance and distance registers
	localparam int MEAN_W     = 12;     // mean_count port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int DVSR_W    = 12;      // divider denominator width
	localparam int DIV_STEPS = 4;       // quotient bits retired per divider cycle

	localparam int Q_DEPTH = 2;         // front-to-back queue entries

	// items the block can hold: queue, back end, output register
	localparam int OUTSTANDING_MAX = Q_DEPTH + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ADC_FLOOR,
		CFG_ADC_FULL_SCALE,
		CFG_DISTANCE_MIN,
		CFG_DISTANCE_SPAN
	} cfg_idx_t;

	typedef struct packed {
		logic [ADC_W-1:0]  adc_floor;
		logic [ADC_W-1:0]  adc_full_scale;
		logic [DIST_W-1:0] distance_min;
		logic [DIST_W-1:0] distance_span;
	} cfg_t;

	localparam logic [ADC_W-1:0]  ADC_FLOOR_RST      = 12'd0;
	localparam logic [ADC_W-1:0]  ADC_FULL_SCALE_RST = 12'd4095;
	localparam logic [DIST_W-1:0] DISTANCE_MIN_RST   = 16'd200;
	localparam logic [DIST_W-1:0] DISTANCE_SPAN_RST  = 16'd4800;

endpackage

>>> sv/asrs_front.sv
`timescale 1ns / 1ps
// Front end: sample window shift line, running sum and fill counter.
// Depends on asrs_pkg; pushes {window_full, sum} into asrs_queue.
module asrs_front #(
	parameter int WINDOW_LEN  = asrs_pkg::WINDOW_LEN_DEF,
	parameter int SAMPLE_BITS = asrs_pkg::SAMPLE_BITS_DEF,
	parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW_LEN)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   push,
	output logic [SUM_W:0]         push_data,
	input  logic                   q_ready
);
	import asrs_pkg::*;

	localparam int FILL_W = $clog2(WINDOW_LEN + 1);

	logic [SAMPLE_BITS-1:0] win_q [WINDOW_LEN];
	logic [SUM_W-1:0]       sum_q;
	logic [FILL_W-1:0]      fill_q;
	logic [SUM_W-1:0]       sum_nxt;
	logic                   full_nxt;

	assign in_ready = q_ready;
	assign push     = in_valid && q_ready;

	// oldest slot leaves, new sample enters
	assign sum_nxt  = sum_q - SUM_W'(win_q[0]) + SUM_W'(sample);
	assign full_nxt = (fill_q == FILL_W'(WINDOW_LEN)) || (fill_q == FILL_W'(WINDOW_LEN - 1));
	assign push_data = {full_nxt, sum_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) win_q[i] <= '0;
			sum_q  <= '0;
			fill_q <= '0;
		end else if (push) begin
			for (int i = 0; i < WINDOW_LEN - 1; i++) win_q[i] <= win_q[i+1];
			win_q[WINDOW_LEN-1] <= sample;
			sum_q <= sum_nxt;
			if (fill_q != FILL_W'(WINDOW_LEN)) fill_q <= fill_q + 1'b1;
		end
	end

endmodule

>>> sv/asrs_queue.sv
`timescale 1ns / 1ps
// Short FIFO between front and back end.
// Depends on asrs_pkg for the default depth.
module asrs_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = asrs_pkg::Q_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              q_ready,
	input  logic              pop,
	output logic              q_valid,
	output logic [DATA_W-1:0] q_data
);
	import asrs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign q_ready = (cnt_q != CNT_W'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_data  = mem_q[rd_q];
	assign do_push = push && q_ready;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> sv/asrs_divider.sv
`timescale 1ns / 1ps
// Iterative restoring divider, DIV_STEPS quotient bits per cycle.
// Depends on asrs_pkg; zero divisor yields an all-ones quotient.
module asrs_divider #(
	parameter int NUM_W = 28
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [NUM_W-1:0]             num,
	input  logic [asrs_pkg::DVSR_W-1:0]  dvsr,
	output logic                         done,
	output logic [NUM_W-1:0]             quot
);
	import asrs_pkg::*;

	localparam int DIV_CYC = NUM_W / DIV_STEPS;
	localparam int CNT_W   = $clog2(DIV_CYC + 1);

	logic [NUM_W-1:0]  num_q;
	logic [DVSR_W-1:0] rem_q;
	logic [DVSR_W-1:0] dvsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [NUM_W-1:0]  num_nxt;
	logic [DVSR_W-1:0] rem_nxt;

	assign done = done_q;
	assign quot = num_q;

	// quotient bits shift in at the bottom as the dividend shifts out the top
	always_comb begin
		logic [DVSR_W:0]   trial;
		logic              ge;
		num_nxt = num_q;
		rem_nxt = rem_q;
		for (int k = 0; k < DIV_STEPS; k++) begin
			trial   = {rem_nxt, num_nxt[NUM_W-1]};
			ge      = (trial >= {1'b0, dvsr_q});
			rem_nxt = ge ? DVSR_W'(trial - {1'b0, dvsr_q}) : trial[DVSR_W-1:0];
			num_nxt = {num_nxt[NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			rem_q  <= '0;
			dvsr_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q  <= num;
				rem_q  <= '0;
				dvsr_q <= dvsr;
				cnt_q  <= CNT_W'(DIV_CYC);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				num_q <= num_nxt;
				rem_q <= rem_nxt;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> sv/asrs_back.sv
`timescale 1ns / 1ps
// Back end: mean by reciprocal multiply, linear distance map, saturation, output register.
// Depends on asrs_pkg and asrs_divider (distance map division).
module asrs_back #(
	parameter int WINDOW_LEN  = asrs_pkg::WINDOW_LEN_DEF,
	parameter int SAMPLE_BITS = asrs_pkg::SAMPLE_BITS_DEF,
	parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW_LEN)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  asrs_pkg::cfg_t                    cfg,
	input  logic                              q_valid,
	input  logic [SUM_W:0]                    q_data,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [asrs_pkg::MEAN_W-1:0]       mean_count,
	output logic [asrs_pkg::DIST_W-1:0]       distance_mm,
	output logic                              window_full,
	output logic                              distance_clipped
);
	import asrs_pkg::*;

	localparam int DIV_W   = SAMPLE_BITS + DIST_W;
	localparam int DIV_CYC = (DIV_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int NUM_W   = DIV_CYC * DIV_STEPS;
	localparam int CMP_W   = (SAMPLE_BITS > ADC_W) ? SAMPLE_BITS : ADC_W;

	localparam int MEAN_SH = SUM_W + $clog2(WINDOW_LEN);
	localparam int RECIP_W = SUM_W + 1;
	localparam int MPROD_W = SUM_W + RECIP_W;
	// ceil(2^MEAN_SH / WINDOW_LEN) gives the exact truncated quotient for any SUM_W-bit sum
	localparam longint unsigned MEAN_RECIP =
		((64'd1 << MEAN_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_DIST,
		B_OUT
	} bstate_t;

	bstate_t                state_q;
	logic [SAMPLE_BITS-1:0] mean_q;
	logic                   full_q;
	logic [DIST_W-1:0]      dist_q;
	logic                   clip_q;
	logic                   div_start_q;
	logic [NUM_W-1:0]       div_num_q;
	logic [DVSR_W-1:0]      div_dvsr_q;
	logic                   div_done;
	logic [NUM_W-1:0]       div_quot;

	logic [MPROD_W-1:0]     mean_prod;
	logic [CMP_W-1:0]       mean_ext;
	logic [CMP_W-1:0]       floor_ext;
	logic                   below_floor;
	logic [SAMPLE_BITS-1:0] diff;
	logic [DIV_W-1:0]       prod;
	logic [DIST_W:0]        dsum;
	logic                   over;

	asrs_divider #(.NUM_W(NUM_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.dvsr   (div_dvsr_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign pop = (state_q == B_IDLE) && q_valid;

	assign mean_prod = MPROD_W'(q_data[SUM_W-1:0]) * MPROD_W'(MEAN_RECIP);

	assign mean_ext    = CMP_W'(mean_q);
	assign floor_ext   = CMP_W'(cfg.adc_floor);
	assign below_floor = mean_ext < floor_ext;
	// floor <= mean on this path, so the difference fits the sample width
	assign diff        = SAMPLE_BITS'(mean_ext - floor_ext);
	assign prod        = DIV_W'(diff) * DIV_W'(cfg.distance_span);

	assign dsum = {1'b0, div_quot[DIST_W-1:0]} + {1'b0, cfg.distance_min};
	assign over = (div_quot[NUM_W-1:DIST_W] != '0) || dsum[DIST_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= B_IDLE;
			mean_q           <= '0;
			full_q           <= 1'b0;
			dist_q           <= '0;
			clip_q           <= 1'b0;
			div_start_q      <= 1'b0;
			div_num_q        <= '0;
			div_dvsr_q       <= '0;
			out_valid        <= 1'b0;
			mean_count       <= '0;
			distance_mm      <= '0;
			window_full      <= 1'b0;
			distance_clipped <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid && out_ready && state_q != B_OUT) out_valid <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						full_q  <= q_data[SUM_W];
						mean_q  <= mean_prod[MEAN_SH +: SAMPLE_BITS];
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					if (below_floor) begin
						dist_q  <= '0;
						clip_q  <= 1'b0;
						state_q <= B_OUT;
					end else begin
						div_num_q   <= NUM_W'(prod);
						div_dvsr_q  <= cfg.adc_full_scale;
						div_start_q <= 1'b1;
						state_q     <= B_DIST;
					end
				end
				B_DIST: begin
					if (div_done) begin
						dist_q  <= over ? '1 : dsum[DIST_W-1:0];
						clip_q  <= over;
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid        <= 1'b1;
						mean_count       <= MEAN_W'(mean_q);
						distance_mm      <= dist_q;
						window_full      <= full_q;
						distance_clipped <= clip_q;
						state_q          <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

>>> sv/averaged_range_sensor_scaler.sv
`timescale 1ns / 1ps
// Averaged range sensor scaler: each sample item enters a WINDOW_LEN-deep window and yields
// one result item with the truncated window mean, the linearly mapped distance in mm
// (zero below adc_floor, saturated at 65535 with distance_clipped) and a window-full flag.
// The front end takes a sample in the cycle it arrives while the two-entry queue has room;
// the back end then works on one item at a time and pops the next only once the result is
// in the output register; the distance map uses a divider that retires four quotient bits a
// cycle and is skipped when the mean is below the floor; the mean comes by reciprocal multiply.
// Configuration registers: 0 adc_floor, 1 adc_full_scale, 2 distance_min, 3 distance_span.
// Depends on asrs_pkg, asrs_front, asrs_queue, asrs_divider and asrs_back.
module averaged_range_sensor_scaler #(
	parameter int WINDOW_LEN  = asrs_pkg::WINDOW_LEN_DEF,
	parameter int SAMPLE_BITS = asrs_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [asrs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [asrs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [SAMPLE_BITS-1:0]              sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [asrs_pkg::MEAN_W-1:0]         mean_count,
	output logic [asrs_pkg::DIST_W-1:0]         distance_mm,
	output logic                                window_full,
	output logic                                distance_clipped
);
	import asrs_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN);

	cfg_t           cfg_q;
	logic           push;
	logic [SUM_W:0] push_data;
	logic           q_ready;
	logic           q_valid;
	logic [SUM_W:0] q_data;
	logic           pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adc_floor      <= ADC_FLOOR_RST;
			cfg_q.adc_full_scale <= ADC_FULL_SCALE_RST;
			cfg_q.distance_min   <= DISTANCE_MIN_RST;
			cfg_q.distance_span  <= DISTANCE_SPAN_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ADC_FLOOR:      cfg_q.adc_floor      <= cfg_data[ADC_W-1:0];
				CFG_ADC_FULL_SCALE: cfg_q.adc_full_scale <= cfg_data[ADC_W-1:0];
				CFG_DISTANCE_MIN:   cfg_q.distance_min   <= cfg_data[DIST_W-1:0];
				CFG_DISTANCE_SPAN:  cfg_q.distance_span  <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	asrs_front #(
		.WINDOW_LEN  (WINDOW_LEN),
		.SAMPLE_BITS (SAMPLE_BITS),
		.SUM_W       (SUM_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.push      (push),
		.push_data (push_data),
		.q_ready   (q_ready)
	);

	asrs_queue #(
		.DATA_W (SUM_W + 1),
		.DEPTH  (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.q_ready   (q_ready),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_data    (q_data)
	);

	asrs_back #(
		.WINDOW_LEN  (WINDOW_LEN),
		.SAMPLE_BITS (SAMPLE_BITS),
		.SUM_W       (SUM_W)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_valid          (q_valid),
		.q_data           (q_data),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.mean_count       (mean_count),
		.distance_mm      (distance_mm),
		.window_full      (window_full),
		.distance_clipped (distance_clipped)
	);

endmodule

>>> sv/asrs_checker.sv
`timescale 1ns / 1ps
// Port-level checker for averaged_range_sensor_scaler, attached by bind.
// Depends on asrs_pkg for the outstanding-item bound.
module asrs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [asrs_pkg::MEAN_W-1:0]   mean_count,
	input logic [asrs_pkg::DIST_W-1:0]   distance_mm,
	input logic                          window_full,
	input logic                          distance_clipped
);
	import asrs_pkg::*;

	localparam int OUT_W = $clog2(OUTSTANDING_MAX + 2);

	logic [OUT_W-1:0] cnt_q;
	logic             full_seen_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			full_seen_q <= 1'b0;
		end else begin
			if (in_acc && !out_acc)      cnt_q <= cnt_q + 1'b1;
			else if (out_acc && !in_acc) cnt_q <= cnt_q - 1'b1;
			if (out_acc && window_full) full_seen_q <= 1'b1;
		end
	end

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OUT_W'(OUTSTANDING_MAX))
		else $error("more items held than the block can store");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0)
		else $error("result item without an accepted input item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_count) &&
			$stable(distance_mm) && $stable(window_full) && $stable(distance_clipped))
		else $error("stalled result item changed");

	a_clip_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && distance_clipped |-> distance_mm == '1)
		else $error("clipped distance not at full scale");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && full_seen_q |-> window_full)
		else $error("window_full dropped after being reported");

endmodule

bind averaged_range_sensor_scaler asrs_checker u_asrs_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for averaged_range_sensor_scaler: sample window mean and distance map.
// Depends on asrs_pkg and the averaged_range_sensor_scaler RTL.
module tb_top;
	import asrs_pkg::*;

	localparam int WIN        = WINDOW_LEN_DEF;
	localparam int HOLD_LEN   = 300;
	localparam int DRAIN_WAIT = 60;

	typedef enum int {RECV_ALWAYS, RECV_RANDOM, RECV_PATTERN} recv_mode_t;

	typedef struct {
		logic [MEAN_W-1:0] mean;
		logic [DIST_W-1:0] dmm;
		logic              full;
		logic              clip;
	} scaled_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_ADC_FLOOR;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [ADC_W-1:0]      sample = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [MEAN_W-1:0]     mean_count;
	logic [DIST_W-1:0]     distance_mm;
	logic                  window_full;
	logic                  distance_clipped;

	averaged_range_sensor_scaler uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.mean_count(mean_count), .distance_mm(distance_mm),
		.window_full(window_full), .distance_clipped(distance_clipped)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [ADC_W-1:0] win_samples [WIN];
	int unsigned      win_sum;
	int unsigned      samples_seen;
	cfg_t             model_cfg;

	logic [ADC_W-1:0]  pending_samples [$];
	scaled_result_t    expected_results [$];

	int errors = 0, n_in = 0, n_out = 0, n_clip = 0, n_below = 0, n_fs_zero = 0, n_settings = 0;

	// sender and receiver control
	bit          send_gaps = 0;
	recv_mode_t  recv_mode = RECV_ALWAYS;
	bit          hold_trigger = 0;
	int          hold_left = 0, pat_cnt = 0;
	int          burst_left = 0, gap_left = 0;
	int unsigned accepted_cnt = 0, seen_cnt = 0;

	// random sample level that drifts so the window mean walks the whole range
	int level = 0, level_left = 0;

	function automatic scaled_result_t scale_sample(logic [ADC_W-1:0] s);
		scaled_result_t r;
		logic [63:0]    prod;
		win_sum = win_sum - win_samples[0];
		for (int i = 0; i < WIN - 1; i++)
			win_samples[i] = win_samples[i + 1];
		win_samples[WIN - 1] = s;
		win_sum = win_sum + s;
		if (samples_seen < WIN)
			samples_seen++;
		r.mean = MEAN_W'(win_sum / WIN);
		r.full = (samples_seen >= WIN);
		r.clip = 1'b0;
		if (r.mean < model_cfg.adc_floor) begin
			r.dmm = '0;
			n_below++;
		end else if (model_cfg.adc_full_scale == 0) begin
			// divider by zero answers all ones
			r.dmm = '1;
			r.clip = 1'b1;
			n_fs_zero++;
		end else begin
			prod = (64'(r.mean) - 64'(model_cfg.adc_floor)) * 64'(model_cfg.distance_span);
			prod = prod / 64'(model_cfg.adc_full_scale) + 64'(model_cfg.distance_min);
			if (prod > 64'hFFFF) begin
				r.dmm = '1;
				r.clip = 1'b1;
			end else begin
				r.dmm = prod[DIST_W-1:0];
			end
		end
		if (r.clip)
			n_clip++;
		return r;
	endfunction

	function automatic logic [ADC_W-1:0] gen_sample();
		int r, v;
		r = $urandom_range(0, 99);
		if (level_left == 0) begin
			level = $urandom_range(0, 4095);
			level_left = $urandom_range(8, 60);
		end
		level_left--;
		if (r < 8)
			return '0;
		if (r < 16)
			return '1;
		if (r < 28)
			return ADC_W'($urandom_range(0, 4095));
		v = level + int'($urandom_range(0, 200)) - 100;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return ADC_W'(v);
	endfunction

	// sender: offers items from pending_samples, in bursts with gaps when send_gaps is set
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || accepted_cnt != seen_cnt) begin
			seen_cnt = accepted_cnt;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				in_valid <= 1'b1;
				sample <= pending_samples[0];
				if (burst_left > 0) begin
					burst_left--;
				end else if (send_gaps) begin
					burst_left = $urandom_range(0, 15);
					gap_left = $urandom_range(1, 25);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			expected_results.push_back(scale_sample(pending_samples.pop_front()));
			accepted_cnt++;
			n_in++;
		end
	end

	// receiver: always ready, random or patterned stalls, plus an optional long hold-off
	always @(negedge clk) begin
		if (hold_trigger) begin
			hold_left = HOLD_LEN;
			hold_trigger = 0;
		end
		pat_cnt = (pat_cnt == 6) ? 0 : pat_cnt + 1;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (recv_mode)
				RECV_ALWAYS: out_ready <= 1'b1;
				RECV_RANDOM: out_ready <= ($urandom_range(0, 99) >= 40);
				default:     out_ready <= (pat_cnt > 2);
			endcase
		end
	end

	scaled_result_t got_exp;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_out++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result item with none expected: mean=%0d dist=%0d full=%0b clip=%0b",
					$time, mean_count, distance_mm, window_full, distance_clipped);
			end else begin
				got_exp = expected_results.pop_front();
				if (mean_count !== got_exp.mean) begin
					errors++;
					$display("%0t: mean_count expected %0d got %0d", $time, got_exp.mean, mean_count);
				end
				if (distance_mm !== got_exp.dmm) begin
					errors++;
					$display("%0t: distance_mm expected %0d got %0d", $time, got_exp.dmm, distance_mm);
				end
				if (window_full !== got_exp.full) begin
					errors++;
					$display("%0t: window_full expected %0b got %0b", $time, got_exp.full, window_full);
				end
				if (distance_clipped !== got_exp.clip) begin
					errors++;
					$display("%0t: distance_clipped expected %0b got %0b",
						$time, got_exp.clip, distance_clipped);
				end
			end
		end
	end

	task automatic drain();
		while (pending_samples.size() != 0 || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// called at a falling edge; leaves cfg_we high for the caller to lower
	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_ADC_FLOOR:      model_cfg.adc_floor = val[ADC_W-1:0];
			CFG_ADC_FULL_SCALE: model_cfg.adc_full_scale = val[ADC_W-1:0];
			CFG_DISTANCE_MIN:   model_cfg.distance_min = val;
			default:            model_cfg.distance_span = val;
		endcase
		@(negedge clk);
	endtask

	// upper bits of the 12-bit registers get junk the block must drop
	task automatic configure(int flr, int fs, int dmin, int span);
		drain();
		write_reg(CFG_ADC_FLOOR, {4'($urandom_range(0, 15)), 12'(flr)});
		write_reg(CFG_ADC_FULL_SCALE, {4'($urandom_range(0, 15)), 12'(fs)});
		write_reg(CFG_DISTANCE_MIN, 16'(dmin));
		write_reg(CFG_DISTANCE_SPAN, 16'(span));
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			pending_samples.push_back(gen_sample());
	endtask

	function automatic int pick16();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 65535;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	initial begin
		int fs;
		for (int i = 0; i < WIN; i++)
			win_samples[i] = '0;
		win_sum = 0;
		samples_seen = 0;
		model_cfg.adc_floor = ADC_FLOOR_RST;
		model_cfg.adc_full_scale = ADC_FULL_SCALE_RST;
		model_cfg.distance_min = DISTANCE_MIN_RST;
		model_cfg.distance_span = DISTANCE_SPAN_RST;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: fill the window, reach full-scale mean, walk bits
		pending_samples.push_back(12'd0);
		pending_samples.push_back(12'd0);
		for (int i = 0; i < WIN + 1; i++)
			pending_samples.push_back(12'hFFF);
		pending_samples.push_back(12'hAAA);
		pending_samples.push_back(12'h555);
		pending_samples.push_back(12'd1);
		pending_samples.push_back(12'd0);
		drain();

		// floor at the top, steep span: mostly below floor
		send_gaps = 1;
		recv_mode = RECV_RANDOM;
		configure(4095, 1, 0, 65535);
		for (int i = 0; i < WIN; i++)
			pending_samples.push_back(12'hFFF);
		queue_random(24);

		// maximum offset and span: saturation
		recv_mode = RECV_PATTERN;
		configure(0, 1, 65535, 65535);
		queue_random(40);

		// full scale of zero
		send_gaps = 0;
		configure(1000, 0, 123, 4800);
		queue_random(40);

		// zero span: distance is the offset alone
		recv_mode = RECV_ALWAYS;
		configure(0, 4095, 777, 0);
		queue_random(30);

		// long receiver hold-off while the sender keeps offering
		configure(500, 3000, 100, 20000);
		queue_random(40);
		@(posedge clk);
		hold_trigger = 1;

		for (int p = 0; p < 8; p++) begin
			send_gaps = $urandom_range(0, 2) != 0;
			recv_mode = recv_mode_t'($urandom_range(0, 2));
			case ($urandom_range(0, 3))
				0:       fs = 1;
				1:       fs = 4095;
				default: fs = $urandom_range(1, 4095);
			endcase
			configure(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4095), fs,
				pick16(), pick16());
			queue_random(50);
		end

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d samples and %0d results over %0d register settings",
			n_in, n_out, n_settings);
		$display("%0d below floor, %0d clipped, %0d with full scale zero",
			n_below, n_clip, n_fs_zero);
		if (errors == 0 && expected_results.size() == 0)
			$display("averaged_range_sensor_scaler verification clean");
		else
			$display("averaged_range_sensor_scaler verification failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout after %0t", $time);
		$display("averaged_range_sensor_scaler verification failed");
		$finish;
	end

endmodule

>>> filelist.f
sv/asrs_pkg.sv
sv/asrs_front.sv
sv/asrs_queue.sv
sv/asrs_divider.sv
sv/asrs_back.sv
sv/averaged_range_sensor_scaler.sv
sv/asrs_checker.sv
test/tb_top.sv
